// ===== rtl/core/tts_pkg.sv =====
// shared types and constants for the timer tick to sample time core
`timescale 1ns / 1ps
package tts_pkg;

    localparam int TS_W      = 32;
    localparam int EXT_W     = 64;
    localparam int SR_W      = 20;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_STEPS = 64;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_HZ    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GUARD       = 2'd2;

    localparam logic CMD_SYNC    = 1'b0;
    localparam logic CMD_CONVERT = 1'b1;

    localparam logic [SR_W-1:0] SAMPLE_RATE_RST = SR_W'(48000);

    typedef struct packed {
        logic load;
        logic step;
    } t_div_ctl;

    typedef struct packed {
        logic clr;
        logic step;
        logic dbit;
    } t_acc_ctl;

endpackage

// ===== rtl/core/timer_tick_to_sample_time_core.sv =====
// top level: timer wrap extension and tick to sample conversion
// synchronize words and convert words with a zero timer rate give their result
// in the cycle after acceptance; a convert word goes through two 64-step serial
// divisions and a 20-step serial multiply before its result is ready.
// one word is in work at a time; a new word waits for idle and a free output.
// synchronous active-low reset clears the counts and loads the register defaults.
`timescale 1ns / 1ps
module timer_tick_to_sample_time_core
    import tts_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_cmd,
    input  logic [TS_W-1:0]      i_now_count,
    input  logic [TS_W-1:0]      i_cap_count,
    input  logic                 i_add_guard,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_ok,
    output logic [EXT_W-1:0]     o_samples
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_TICKS = 4'd1;
    localparam logic [3:0] ST_MAG   = 4'd2;
    localparam logic [3:0] ST_DIV1  = 4'd3;
    localparam logic [3:0] ST_SAVE  = 4'd4;
    localparam logic [3:0] ST_MUL   = 4'd5;
    localparam logic [3:0] ST_LOAD2 = 4'd6;
    localparam logic [3:0] ST_DIV2  = 4'd7;
    localparam logic [3:0] ST_SUM   = 4'd8;
    localparam logic [3:0] ST_SIGN  = 4'd9;
    localparam logic [3:0] ST_OUT   = 4'd10;

    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(SR_W - 1);

    logic [3:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [TS_W-1:0]  r_hz;
    logic [SR_W-1:0]  r_sr;
    logic [TS_W-1:0]  r_guard;
    logic [TS_W-1:0]  r_last;
    logic [EXT_W-1:0] r_ext;
    logic [TS_W-1:0]  r_off;
    logic [EXT_W-1:0] r_val;
    logic [EXT_W-1:0] r_wsr;
    logic [SR_W-1:0]  r_srsh;
    logic             r_neg;
    logic             r_guard_on;
    logic             r_out_valid;
    logic             r_ok;
    logic [EXT_W-1:0] r_st;

    logic             w_in_acc;
    logic             w_out_free;
    logic             w_out_load;
    t_div_ctl         w_div_ctl;
    t_acc_ctl         w_acc_ctl;
    logic [EXT_W-1:0] w_dividend;
    logic [EXT_W-1:0] w_addend;
    logic             w_q_bit;
    logic [TS_W-1:0]  w_rem;
    logic [EXT_W-1:0] w_acc;
    logic [EXT_W:0]   w_guard_sum;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = i_rst_n && (r_state == ST_IDLE) && w_out_free;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_ok        = r_ok;
    assign o_samples   = r_st;

    assign w_out_load = ((r_state == ST_IDLE) && w_in_acc
                         && ((i_cmd == CMD_SYNC) || (r_hz == '0)))
                        || ((r_state == ST_OUT) && w_out_free);

    assign w_guard_sum = {1'b0, r_val} + (r_guard_on ? {{(EXT_W-TS_W+1){1'b0}}, r_guard} : '0);

    always_comb begin
        w_div_ctl  = '0;
        w_acc_ctl  = '0;
        w_dividend = r_val[EXT_W-1] ? (~r_val + EXT_W'(1)) : r_val;
        w_addend   = {{(EXT_W-SR_W){1'b0}}, r_sr};
        case (r_state)
            ST_MAG: begin
                w_div_ctl.load = 1'b1;
                w_acc_ctl.clr  = 1'b1;
            end
            ST_DIV1: begin
                w_div_ctl.step = 1'b1;
                w_acc_ctl.step = 1'b1;
                w_acc_ctl.dbit = w_q_bit;
            end
            ST_SAVE: begin
                w_acc_ctl.clr = 1'b1;
            end
            ST_MUL: begin
                w_acc_ctl.step = 1'b1;
                w_acc_ctl.dbit = r_srsh[SR_W-1];
                w_addend       = {{(EXT_W-TS_W){1'b0}}, w_rem};
            end
            ST_LOAD2: begin
                w_div_ctl.load = 1'b1;
                w_acc_ctl.clr  = 1'b1;
                w_dividend     = w_acc + {{(EXT_W-TS_W+1){1'b0}}, r_hz[TS_W-1:1]};
            end
            ST_DIV2: begin
                w_div_ctl.step = 1'b1;
                w_acc_ctl.step = 1'b1;
                w_acc_ctl.dbit = w_q_bit;
                w_addend       = EXT_W'(1);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && (i_cmd == CMD_CONVERT) && (r_hz != '0)) begin
                    n_state = ST_TICKS;
                end
            end
            ST_TICKS: n_state = ST_MAG;
            ST_MAG:   n_state = ST_DIV1;
            ST_DIV1:  if (r_cnt == DIV_LAST) n_state = ST_SAVE;
            ST_SAVE:  n_state = ST_MUL;
            ST_MUL:   if (r_cnt == MUL_LAST) n_state = ST_LOAD2;
            ST_LOAD2: n_state = ST_DIV2;
            ST_DIV2:  if (r_cnt == DIV_LAST) n_state = ST_SUM;
            ST_SUM:   n_state = ST_SIGN;
            ST_SIGN:  n_state = ST_OUT;
            ST_OUT:   if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_hz        <= '0;
            r_sr        <= SAMPLE_RATE_RST;
            r_guard     <= '0;
            r_last      <= '0;
            r_ext       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TIMER_HZ:    r_hz    <= i_cfg_data[TS_W-1:0];
                    CFG_SAMPLE_RATE: r_sr    <= i_cfg_data[SR_W-1:0];
                    CFG_GUARD:       r_guard <= i_cfg_data[TS_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        if (i_cmd == CMD_SYNC) begin
                            r_last <= i_now_count;
                            r_ext  <= {{(EXT_W-TS_W){1'b0}}, i_now_count};
                            r_ok   <= 1'b1;
                            r_st   <= '0;
                        end else if (r_hz == '0) begin
                            r_ok <= 1'b0;
                            r_st <= '0;
                        end else begin
                            r_ext      <= r_ext + {{(EXT_W-TS_W){1'b0}}, i_now_count - r_last};
                            r_last     <= i_now_count;
                            r_off      <= i_cap_count - i_now_count;
                            r_guard_on <= i_add_guard;
                        end
                    end
                end
                ST_TICKS: r_val <= r_ext + {{(EXT_W-TS_W){r_off[TS_W-1]}}, r_off};
                ST_MAG: begin
                    r_neg <= r_val[EXT_W-1];
                    r_cnt <= '0;
                end
                ST_DIV1: r_cnt <= r_cnt + CNT_W'(1);
                ST_SAVE: begin
                    r_wsr  <= w_acc;
                    r_srsh <= r_sr;
                    r_cnt  <= '0;
                end
                ST_MUL: begin
                    r_srsh <= {r_srsh[SR_W-2:0], 1'b0};
                    r_cnt  <= r_cnt + CNT_W'(1);
                end
                ST_LOAD2: r_cnt <= '0;
                ST_DIV2:  r_cnt <= r_cnt + CNT_W'(1);
                ST_SUM:   r_wsr <= r_wsr + w_acc;
                ST_SIGN:  r_val <= r_neg ? (~r_wsr + EXT_W'(1)) : r_wsr;
                ST_OUT: begin
                    if (w_out_free) begin
                        if (r_val[EXT_W-1]) begin
                            r_ok <= 1'b0;
                            r_st <= '0;
                        end else begin
                            r_ok <= 1'b1;
                            r_st <= w_guard_sum[EXT_W] ? '1 : w_guard_sum[EXT_W-1:0];
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    tts_div u_div (
        .i_clk      (i_clk),
        .i_ctl      (w_div_ctl),
        .i_dividend (w_dividend),
        .i_divisor  (r_hz),
        .o_q_bit    (w_q_bit),
        .o_rem      (w_rem)
    );

    tts_acc u_acc (
        .i_clk    (i_clk),
        .i_ctl    (w_acc_ctl),
        .i_addend (w_addend),
        .o_acc    (w_acc)
    );

endmodule

// ===== rtl/core/tts_div.sv =====
// bit-serial restoring divider, one quotient bit per step
`timescale 1ns / 1ps
module tts_div
    import tts_pkg::*;
(
    input  logic             i_clk,
    input  t_div_ctl         i_ctl,
    input  logic [EXT_W-1:0] i_dividend,
    input  logic [TS_W-1:0]  i_divisor,
    output logic             o_q_bit,
    output logic [TS_W-1:0]  o_rem
);

    logic [EXT_W-1:0] r_dvd;
    logic [TS_W-1:0]  r_rem;
    logic [TS_W:0]    w_trial;
    logic [TS_W:0]    w_diff;

    assign w_trial = {r_rem, r_dvd[EXT_W-1]};
    assign w_diff  = w_trial - {1'b0, i_divisor};
    assign o_q_bit = (w_trial >= {1'b0, i_divisor});
    assign o_rem   = r_rem;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (i_ctl.step) begin
            r_dvd <= {r_dvd[EXT_W-2:0], 1'b0};
            r_rem <= o_q_bit ? w_diff[TS_W-1:0] : w_trial[TS_W-1:0];
        end
    end

endmodule

// ===== rtl/core/tts_acc.sv =====
// msb-first shift-and-add accumulator for serial products and quotients
`timescale 1ns / 1ps
module tts_acc
    import tts_pkg::*;
(
    input  logic             i_clk,
    input  t_acc_ctl         i_ctl,
    input  logic [EXT_W-1:0] i_addend,
    output logic [EXT_W-1:0] o_acc
);

    logic [EXT_W-1:0] r_acc;

    assign o_acc = r_acc;

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (i_ctl.step) begin
            r_acc <= {r_acc[EXT_W-2:0], 1'b0} + (i_ctl.dbit ? i_addend : '0);
        end
    end

endmodule

// ===== rtl/core/tts_checker.sv =====
// port-level checker for the timer tick to sample time core, bound to the top
`timescale 1ns / 1ps
module tts_checker
    import tts_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic                 i_cmd,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic                 o_ok,
    input logic [EXT_W-1:0]     o_samples
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_ok) && $stable(o_samples))
        else $error("result word changed while stalled");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_ok |-> o_samples == '0)
        else $error("failed result carries a nonzero sample time");

    a_sync_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_cmd == CMD_SYNC)
        |=> o_out_valid && o_ok && (o_samples == '0))
        else $error("synchronize word did not give its result");

    // a convert holds off input, or with no timer rate fails at once
    a_convert_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_cmd == CMD_CONVERT)
        |=> !o_in_ready || (o_out_valid && !o_ok))
        else $error("input taken while a conversion is in work");

endmodule

bind timer_tick_to_sample_time_core tts_checker u_tts_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_cmd         (i_cmd),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_ok          (o_ok),
    .o_samples     (o_samples)
);

// ===== tb/tts_sample_time_checker.sv =====
// checker for the tick to sample time core: predicts each result word and compares
`timescale 1ns / 1ps
module tts_result_checker
    import tts_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic                 i_cmd,
    input  logic [TS_W-1:0]      i_now_count,
    input  logic [TS_W-1:0]      i_cap_count,
    input  logic                 i_add_guard,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic                 i_ok,
    input  logic [EXT_W-1:0]     i_samples,
    output int                   o_pending,
    output int                   o_fail_count
);

    typedef struct packed {
        logic             ok;
        logic [EXT_W-1:0] samples;
    } t_result;

    logic [TS_W-1:0]  timer_hz;
    logic [SR_W-1:0]  sample_rate;
    logic [TS_W-1:0]  guard_samples;
    logic [TS_W-1:0]  prev_tick;
    logic [EXT_W-1:0] ext_ticks;

    t_result expected_samples[$];
    t_result want;

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
    end

    function automatic logic [EXT_W-1:0] ticks_to_samples(input logic [EXT_W-1:0] ticks);
        logic             neg;
        logic [EXT_W-1:0] mag;
        logic [EXT_W-1:0] hz;
        logic [EXT_W-1:0] rate;
        logic [EXT_W-1:0] whole;
        logic [EXT_W-1:0] rem;
        logic [EXT_W-1:0] rounded;
        logic [EXT_W-1:0] mag_samples;
        neg         = ticks[EXT_W-1];
        mag         = neg ? (64'd0 - ticks) : ticks;
        hz          = {32'd0, timer_hz};
        rate        = {44'd0, sample_rate};
        whole       = mag / hz;
        rem         = mag % hz;
        rounded     = (rem * rate + (hz >> 1)) / hz;
        mag_samples = whole * rate + rounded;
        return neg ? (64'd0 - mag_samples) : mag_samples;
    endfunction

    function automatic t_result predict_result(
        input logic            cmd,
        input logic [TS_W-1:0] now_count,
        input logic [TS_W-1:0] cap_count,
        input logic            add_guard
    );
        t_result          res;
        logic [TS_W-1:0]  delta;
        logic [TS_W-1:0]  cap_diff;
        logic [EXT_W-1:0] ticks;
        logic [EXT_W-1:0] samples;
        logic [EXT_W-1:0] guard_wide;
        res = '0;
        if (cmd == CMD_SYNC) begin
            prev_tick = now_count;
            ext_ticks = {32'd0, now_count};
            res.ok    = 1'b1;
        end else if (timer_hz != '0) begin
            delta     = now_count - prev_tick;
            ext_ticks = ext_ticks + {32'd0, delta};
            prev_tick = now_count;
            cap_diff  = cap_count - now_count;
            ticks     = ext_ticks + {{32{cap_diff[TS_W-1]}}, cap_diff};
            samples   = ticks_to_samples(ticks);
            if (!samples[EXT_W-1]) begin
                if (add_guard) begin
                    guard_wide = {32'd0, guard_samples};
                    if (samples > ({EXT_W{1'b1}} - guard_wide)) begin
                        samples = {EXT_W{1'b1}};
                    end else begin
                        samples = samples + guard_wide;
                    end
                end
                res.ok      = 1'b1;
                res.samples = samples;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            timer_hz      = '0;
            sample_rate   = SAMPLE_RATE_RST;
            guard_samples = '0;
            prev_tick     = '0;
            ext_ticks     = '0;
            expected_samples.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TIMER_HZ: begin
                        timer_hz = i_cfg_data;
                    end
                    CFG_SAMPLE_RATE: begin
                        sample_rate = i_cfg_data[SR_W-1:0];
                    end
                    CFG_GUARD: begin
                        guard_samples = i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_samples.size() == 0) begin
                    $error("unexpected result word: ok %0b samples %0d",
                           i_ok, i_samples);
                    o_fail_count++;
                end else begin
                    want = expected_samples.pop_front();
                    if (i_ok !== want.ok) begin
                        $error("ok: expected %0b, got %0b", want.ok, i_ok);
                        o_fail_count++;
                    end
                    if (i_samples !== want.samples) begin
                        $error("samples: expected %0d, got %0d",
                               want.samples, i_samples);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_samples.push_back(
                    predict_result(i_cmd, i_now_count, i_cap_count, i_add_guard));
            end
        end
        o_pending <= expected_samples.size();
    end

endmodule

// ===== tb/timer_tick_to_sample_time_core_test.sv =====
// testbench top for the tick to sample time core: stimulus, flow control and verdict
`timescale 1ns / 1ps
module timer_tick_to_sample_time_core_test;
    import tts_pkg::*;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index    = CFG_TIMER_HZ;
    logic [CFG_W-1:0]     i_cfg_data     = '0;
    logic                 i_in_valid     = 1'b0;
    logic                 o_in_ready;
    logic                 i_cmd          = CMD_SYNC;
    logic [TS_W-1:0]      i_now_count    = '0;
    logic [TS_W-1:0]      i_cap_count    = '0;
    logic                 i_add_guard    = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready    = 1'b0;
    logic                 o_ok;
    logic [EXT_W-1:0]     o_samples;

    int samples_in_flight;
    int sample_mismatches;

    int              send_idle_pct  = 0;
    int              recv_stall_pct = 0;
    bit              hold_ask       = 1'b0;
    int              hold_left      = 0;
    logic [TS_W-1:0] timer_now      = '0;

    timer_tick_to_sample_time_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_now_count    (i_now_count),
        .i_cap_count    (i_cap_count),
        .i_add_guard    (i_add_guard),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_ok           (o_ok),
        .o_samples      (o_samples)
    );

    tts_result_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_now_count    (i_now_count),
        .i_cap_count    (i_cap_count),
        .i_add_guard    (i_add_guard),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_ok           (o_ok),
        .i_samples      (o_samples),
        .o_pending      (samples_in_flight),
        .o_fail_count   (sample_mismatches)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("** timer_tick_to_sample_time_core: FAILED **");
        $finish;
    end

    // result side: random stalls plus a single long hold-off
    always @(posedge i_clk) begin
        if (hold_ask) begin
            hold_left = 400;
            hold_ask  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic send_word(
        input logic            cmd,
        input logic [TS_W-1:0] now_count,
        input logic [TS_W-1:0] cap_count,
        input logic            add_guard
    );
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_cmd       <= cmd;
        i_now_count <= now_count;
        i_cap_count <= cap_count;
        i_add_guard <= add_guard;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (samples_in_flight != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic configure(
        input logic [CFG_W-1:0] hz,
        input logic [CFG_W-1:0] rate,
        input logic [CFG_W-1:0] guard
    );
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_TIMER_HZ;
        i_cfg_data  <= hz;
        @(posedge i_clk);
        i_cfg_index <= CFG_SAMPLE_RATE;
        i_cfg_data  <= rate;
        @(posedge i_clk);
        i_cfg_index <= CFG_GUARD;
        i_cfg_data  <= guard;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic run_directed();
        // timer rate still zero after reset
        send_word(CMD_CONVERT, 32'd5, 32'd5, 1'b0);
        send_word(CMD_SYNC, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 1'b1);
        configure(32'd24_000_000, 32'd48000, 32'hFFFF_FFFF);
        // timer wrap since the sync
        send_word(CMD_CONVERT, 32'h0000_0010, 32'h0000_0010, 1'b0);
        send_word(CMD_CONVERT, 32'h0000_0020, 32'h0000_0000, 1'b1);
        send_word(CMD_CONVERT, 32'h0000_0030, 32'h8000_0030, 1'b0);
        send_word(CMD_SYNC, 32'h0000_0000, 32'h0000_0000, 1'b0);
        // capture just before zero gives a negative time
        send_word(CMD_CONVERT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
        send_word(CMD_CONVERT, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1);
        // rounding of half a sample
        configure(32'd2, 32'd1, 32'd0);
        send_word(CMD_SYNC, 32'h0000_0000, 32'h0000_0000, 1'b0);
        send_word(CMD_CONVERT, 32'h0000_0000, 32'h0000_0001, 1'b0);
        send_word(CMD_CONVERT, 32'h0000_0000, 32'h0000_0003, 1'b0);
        send_word(CMD_CONVERT, 32'h0000_0000, 32'h0000_0002, 1'b1);
        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_SYNC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_word(CMD_CONVERT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
        send_word(CMD_CONVERT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        // sample rate of zero
        configure(32'd1, 32'hFFF0_0000, 32'd5);
        send_word(CMD_CONVERT, 32'd1000, 32'd2000, 1'b1);
        send_word(CMD_CONVERT, 32'd1000, 32'd2000, 1'b0);
        configure(32'd0, 32'd48000, 32'd0);
        send_word(CMD_CONVERT, 32'd3000, 32'd3000, 1'b1);
        send_word(CMD_SYNC, 32'd77, 32'd0, 1'b0);
    endtask

    task automatic send_random_item();
        int              pick;
        logic [TS_W-1:0] cap;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            timer_now = timer_now + $urandom;
        end else begin
            timer_now = timer_now + $urandom_range(0, 32'h40_0000);
        end
        if ($urandom_range(0, 99) < 80) begin
            cap = timer_now - $urandom_range(0, 32'h10_0000);
        end else begin
            cap = timer_now + $urandom_range(0, 32'h1_0000);
        end
        if (pick >= 90) begin
            send_word(1'($urandom_range(0, 1)), $urandom, $urandom,
                      1'($urandom_range(0, 1)));
        end else if (pick >= 82) begin
            send_word(CMD_SYNC, timer_now, $urandom, 1'($urandom_range(0, 1)));
        end else begin
            send_word(CMD_CONVERT, timer_now, cap, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic configure_segment(input int seg);
        case (seg)
            0: configure(32'd24_000_000, 32'd48000, $urandom);
            1: configure(32'd1, 32'd1_000_000, 32'hFFFF_FFFF);
            2: configure(32'hFFFF_FFFF, 32'd1, 32'd0);
            3: configure($urandom, $urandom_range(1, 1_000_000), $urandom);
            4: configure(32'd32768, 32'd44100, $urandom_range(0, 4096));
            5: configure($urandom_range(1, 1000), $urandom, $urandom);
            6: configure(32'd19_200_000, 32'h5A5F_FFFF, $urandom);
            default: configure($urandom_range(1, 32'h10_0000),
                               $urandom_range(1, 1_000_000), $urandom);
        endcase
    endtask

    initial begin
        int seg;
        int k;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        for (seg = 0; seg < 8; seg++) begin
            case (seg / 2)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 49;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 49;
                end
                default: begin
                    send_idle_pct  = 37;
                    recv_stall_pct = 37;
                end
            endcase
            configure_segment(seg);
            for (k = 0; k < 129; k++) begin
                if (seg == 0 && k == 20) begin
                    hold_ask = 1'b1;
                end
                if (seg == 3 && k == 60) begin
                    wait_drained();
                end
                send_random_item();
            end
        end
        wait_drained();
        repeat (200) @(posedge i_clk);
        if (sample_mismatches == 0) begin
            $display("** timer_tick_to_sample_time_core: PASSED **");
        end else begin
            $display("** timer_tick_to_sample_time_core: FAILED **");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/tts_pkg.sv
rtl/core/tts_div.sv
rtl/core/tts_acc.sv
rtl/core/timer_tick_to_sample_time_core.sv
rtl/core/tts_checker.sv
tb/tts_sample_time_checker.sv
tb/timer_tick_to_sample_time_core_test.sv
